// ===== hdl/nps_pkg.sv =====
// nps_pkg: shared types, constants and helpers for the nearest point search block
// depends on nothing; every other file but nps_ram refers to it by scoped names
package nps_pkg;

    // largest number of entries that an 8-bit entry index can reach
    localparam int MAX_ENTRIES = 256;

    // default table depth and depth of the queue between front and back
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 2;

    // payload widths
    localparam int COORD_W = 16;
    localparam int INDEX_W = 8;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int DIST_W  = 36;

    // kind of work that the back end carries out
    typedef enum logic [0:0] {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // input opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SCAN   = 2'd1,
        BK_DRAIN  = 2'd2,
        BK_FINISH = 2'd3
    } back_state_t;

    // classified item passed through the queue
    typedef struct packed {
        kind_t                      kind;
        logic [INDEX_W-1:0]         index;
        logic                       used;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } cmd_t;

    // entries actually reachable by a write
    function automatic int eff_depth(input int depth);
        return (depth < MAX_ENTRIES) ? depth : MAX_ENTRIES;
    endfunction

endpackage

// ===== hdl/nps_in_if.sv =====
// nps_in_if: input channel of the nearest point search block
// valid/ready handshake with the write or query item; uses nps_pkg widths
interface nps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic [nps_pkg::INDEX_W-1:0]          entry_index;
    logic                                 entry_valid;
    logic signed [nps_pkg::COORD_W-1:0]   point_x;
    logic signed [nps_pkg::COORD_W-1:0]   point_y;
    logic signed [nps_pkg::COORD_W-1:0]   point_z;

    modport source (
        output valid, opcode, entry_index, entry_valid, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, entry_valid, point_x, point_y, point_z,
        output ready
    );
endinterface

// ===== hdl/nps_out_if.sv =====
// nps_out_if: result channel of the nearest point search block
// valid/ready handshake with the query result; uses nps_pkg widths
interface nps_out_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [nps_pkg::INDEX_W-1:0]     nearest_index;
    logic [nps_pkg::DIST_W-1:0]      nearest_distance;

    modport source (
        output valid, found, nearest_index, nearest_distance,
        input  ready
    );
    modport sink (
        input  valid, found, nearest_index, nearest_distance,
        output ready
    );
endinterface

// ===== hdl/nps_ram.sv =====
// nps_ram: generic single-port RAM with registered read data
// depends on nothing
module nps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle, write or read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/nps_front.sv =====
// nps_front: accepts input items and classifies them for the back end
// depends on nps_pkg and nps_in_if; feeds nps_queue
module nps_front #(
    parameter int TABLE_DEPTH = nps_pkg::TABLE_DEPTH_DEF
) (
    nps_in_if.sink          cmd,
    output logic            enq_valid,
    output nps_pkg::cmd_t   enq_item,
    input  logic            enq_ready
);

    localparam int EFF_DEPTH = nps_pkg::eff_depth(TABLE_DEPTH);

    logic in_range;
    logic keep;

    // writes beyond the table are taken and dropped here
    assign in_range = ({1'b0, cmd.entry_index} < (nps_pkg::INDEX_W + 1)'(EFF_DEPTH));
    assign keep     = (cmd.opcode == nps_pkg::OP_QUERY) || in_range;

    assign cmd.ready = enq_ready;
    assign enq_valid = cmd.valid && keep;

    // build the queue item
    always_comb
    begin
        enq_item.kind  = (cmd.opcode == nps_pkg::OP_QUERY) ? nps_pkg::KIND_QUERY
                                                           : nps_pkg::KIND_WRITE;
        enq_item.index = cmd.entry_index;
        enq_item.used  = cmd.entry_valid;
        enq_item.x     = cmd.point_x;
        enq_item.y     = cmd.point_y;
        enq_item.z     = cmd.point_z;
    end

endmodule

// ===== hdl/nps_queue.sv =====
// nps_queue: short fifo of classified items between front and back
// depends on nps_pkg
module nps_queue #(
    parameter int DEPTH = nps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            enq_valid,
    input  nps_pkg::cmd_t   enq_item,
    output logic            enq_ready,
    output logic            deq_valid,
    output nps_pkg::cmd_t   deq_item,
    input  logic            deq_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    nps_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push;
    logic           pop;

    assign enq_ready = (count_reg != CW'(DEPTH));
    assign deq_valid = (count_reg != '0);
    assign deq_item  = mem_reg[rd_ptr_reg];
    assign push      = enq_valid && enq_ready;
    assign pop       = deq_ready && deq_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= enq_item;
        end
    end

endmodule

// ===== hdl/nps_back.sv =====
// nps_back: carries out table writes and nearest point scans, holds the result register
// depends on nps_pkg, nps_out_if and nps_ram
module nps_back #(
    parameter int TABLE_DEPTH = nps_pkg::TABLE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            deq_valid,
    input  nps_pkg::cmd_t   deq_item,
    output logic            deq_ready,
    nps_out_if.source       res
);

    localparam int EFF_DEPTH = nps_pkg::eff_depth(TABLE_DEPTH);
    localparam int IDX_W     = $clog2(EFF_DEPTH);
    localparam int PT_W      = 3 * nps_pkg::COORD_W;
    localparam int CW        = nps_pkg::COORD_W;

    nps_pkg::back_state_t state_reg, state_next;

    // sequencer outputs
    logic               ram_en;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [PT_W-1:0]    ram_wdata;
    logic [PT_W-1:0]    ram_rdata;
    logic               issue;
    logic               start_query;
    logic               write_entry;
    logic               load_result;
    logic               res_slot_free;
    logic               pipe_busy;

    // table state
    logic [EFF_DEPTH-1:0] used_reg;
    logic [IDX_W-1:0]     scan_addr_reg;
    logic signed [CW-1:0] qx_reg, qy_reg, qz_reg;

    // scan pipeline
    logic                          s1_valid_reg, s1_hit_reg;
    logic [IDX_W-1:0]              s1_idx_reg;
    logic                          s2_valid_reg, s2_hit_reg;
    logic [IDX_W-1:0]              s2_idx_reg;
    logic [nps_pkg::SQ_W-1:0]      sqx_reg, sqy_reg, sqz_reg;
    logic                          s3_valid_reg, s3_hit_reg;
    logic [IDX_W-1:0]              s3_idx_reg;
    logic [nps_pkg::SUM_W-1:0]     sum_reg;

    // running best
    logic                          best_found_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [nps_pkg::SUM_W-1:0]     best_dist_reg;

    // result register
    logic                          res_valid_reg;
    logic                          res_found_reg;
    logic [nps_pkg::INDEX_W-1:0]   res_idx_reg;
    logic [nps_pkg::DIST_W-1:0]    res_dist_reg;

    logic signed [CW-1:0]                 tx, ty, tz;
    logic signed [nps_pkg::DIFF_W-1:0]    dx, dy, dz;
    logic signed [2*nps_pkg::DIFF_W-1:0]  px, py, pz;
    logic                                 better;

    assign res_slot_free = !res_valid_reg || res.ready;
    assign pipe_busy     = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign ram_wdata     = {deq_item.x, deq_item.y, deq_item.z};

    // point memory
    nps_ram #(
        .WIDTH (PT_W),
        .DEPTH (EFF_DEPTH)
    ) u_point_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nps_pkg::BK_IDLE:
            begin
                if (deq_valid && (deq_item.kind == nps_pkg::KIND_QUERY))
                begin
                    state_next = nps_pkg::BK_SCAN;
                end
            end
            nps_pkg::BK_SCAN:
            begin
                if (scan_addr_reg == IDX_W'(EFF_DEPTH - 1))
                begin
                    state_next = nps_pkg::BK_DRAIN;
                end
            end
            nps_pkg::BK_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = nps_pkg::BK_FINISH;
                end
            end
            nps_pkg::BK_FINISH:
            begin
                if (res_slot_free)
                begin
                    state_next = nps_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = nps_pkg::BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        deq_ready   = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = scan_addr_reg;
        issue       = 1'b0;
        start_query = 1'b0;
        write_entry = 1'b0;
        load_result = 1'b0;
        unique case (state_reg)
            nps_pkg::BK_IDLE:
            begin
                if (deq_valid)
                begin
                    deq_ready = 1'b1;
                    if (deq_item.kind == nps_pkg::KIND_WRITE)
                    begin
                        write_entry = 1'b1;
                        ram_en      = 1'b1;
                        ram_we      = 1'b1;
                        ram_addr    = deq_item.index[IDX_W-1:0];
                    end
                    else
                    begin
                        start_query = 1'b1;
                    end
                end
            end
            nps_pkg::BK_SCAN:
            begin
                ram_en = 1'b1;
                issue  = 1'b1;
            end
            nps_pkg::BK_DRAIN:
            begin
                issue = 1'b0;
            end
            nps_pkg::BK_FINISH:
            begin
                load_result = res_slot_free;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // squared differences against the entry just read
    assign {tx, ty, tz} = ram_rdata;
    assign dx = $signed({qx_reg[CW-1], qx_reg}) - $signed({tx[CW-1], tx});
    assign dy = $signed({qy_reg[CW-1], qy_reg}) - $signed({ty[CW-1], ty});
    assign dz = $signed({qz_reg[CW-1], qz_reg}) - $signed({tz[CW-1], tz});
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    // strict compare keeps the lowest index on ties
    assign better = s3_valid_reg && s3_hit_reg && (!best_found_reg || (sum_reg < best_dist_reg));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nps_pkg::BK_IDLE;
            used_reg       <= '0;
            scan_addr_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (write_entry)
            begin
                used_reg[deq_item.index[IDX_W-1:0]] <= deq_item.used;
            end
            if (start_query)
            begin
                scan_addr_reg <= '0;
            end
            else if (issue)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (start_query)
            begin
                best_found_reg <= 1'b0;
            end
            else if (better)
            begin
                best_found_reg <= 1'b1;
            end
            if (load_result)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            qx_reg        <= deq_item.x;
            qy_reg        <= deq_item.y;
            qz_reg        <= deq_item.z;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
        end
        else if (better)
        begin
            best_idx_reg  <= s3_idx_reg;
            best_dist_reg <= sum_reg;
        end
        // stage 1 aligns with the memory read data
        s1_idx_reg <= scan_addr_reg;
        s1_hit_reg <= issue && used_reg[scan_addr_reg];
        // stage 2 holds the squares
        s2_idx_reg <= s1_idx_reg;
        s2_hit_reg <= s1_hit_reg;
        sqx_reg    <= px[nps_pkg::SQ_W-1:0];
        sqy_reg    <= py[nps_pkg::SQ_W-1:0];
        sqz_reg    <= pz[nps_pkg::SQ_W-1:0];
        // stage 3 holds the distance
        s3_idx_reg <= s2_idx_reg;
        s3_hit_reg <= s2_hit_reg;
        sum_reg    <= nps_pkg::SUM_W'(sqx_reg) + nps_pkg::SUM_W'(sqy_reg)
                    + nps_pkg::SUM_W'(sqz_reg);
        if (load_result)
        begin
            res_found_reg <= best_found_reg;
            res_idx_reg   <= nps_pkg::INDEX_W'(best_idx_reg);
            res_dist_reg  <= nps_pkg::DIST_W'(best_dist_reg);
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.found            = res_found_reg;
    assign res.nearest_index    = res_idx_reg;
    assign res.nearest_distance = res_dist_reg;

    // a waiting result is never overwritten
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |=> res_valid_reg && $stable(res_idx_reg)
            && $stable(res_dist_reg) && $stable(res_found_reg))
        else $error("result changed while waiting");

    // an empty table reports index and distance zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_found_reg |-> res_idx_reg == '0 && res_dist_reg == '0)
        else $error("empty result not zero");

    // a found index lies inside the table
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_found_reg
            |-> {1'b0, res_idx_reg} < (nps_pkg::INDEX_W + 1)'(EFF_DEPTH))
        else $error("nearest index beyond table");

    // scan data only in flight while a query is running
    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> state_reg == nps_pkg::BK_SCAN || state_reg == nps_pkg::BK_DRAIN)
        else $error("scan pipeline active outside a query");

endmodule

// ===== hdl/nearest_point_search_top.sv =====
// Nearest point search: a table of 3D points (signed Q8.8) with used marks cleared at reset.
// A write item stores a point and its used mark and gives no result; a query item returns
// the lowest-index used entry at least squared distance, the distance (Q20.16) and a found
// flag. Items enter through a front end and a short queue, so the input keeps accepting
// while the back end works or a result waits, until the queue fills. A query scans all
// min(TABLE_DEPTH, 256) table entries: the scan reads one entry per cycle from the
// single-port point memory, followed by a three-stage distance pipeline and the result
// load. Writes with an entry index beyond the table are accepted and dropped.
// depends on nps_pkg, nps_in_if, nps_out_if, nps_front, nps_queue, nps_back
module nearest_point_search_top #(
    parameter int TABLE_DEPTH = nps_pkg::TABLE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = nps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    nps_in_if.sink     cmd,
    nps_out_if.source  res
);

    logic           enq_valid;
    logic           enq_ready;
    nps_pkg::cmd_t  enq_item;
    logic           deq_valid;
    logic           deq_ready;
    nps_pkg::cmd_t  deq_item;

    // accept and classify
    nps_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .cmd       (cmd),
        .enq_valid (enq_valid),
        .enq_item  (enq_item),
        .enq_ready (enq_ready)
    );

    // decoupling queue
    nps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (enq_valid),
        .enq_item  (enq_item),
        .enq_ready (enq_ready),
        .deq_valid (deq_valid),
        .deq_item  (deq_item),
        .deq_ready (deq_ready)
    );

    // table writes and scans
    nps_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .deq_valid (deq_valid),
        .deq_item  (deq_item),
        .deq_ready (deq_ready),
        .res       (res)
    );

endmodule
